// ===== rtl/per_thread_call_timer_stack_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-thread call timer stack
// Clocked on i_clk; the reset-qualified form skips cycles in reset.
// ----------------------------------------------------------------------------
`ifndef PER_THREAD_CALL_TIMER_STACK_ASSERT_SVH
`define PER_THREAD_CALL_TIMER_STACK_ASSERT_SVH

// checked only out of reset
`define PCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/pct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// Shared widths, codes and control structs of the call timer stack.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int TID_W       = 22;
    localparam int CALL_ADDR_W = 48;
    localparam int TS_W        = 64;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 5;

    // event kinds
    localparam logic MODE_ENTRY  = 1'b0;
    localparam logic MODE_RETURN = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 2'd2;

    // lookup result of the thread table
    typedef struct packed {
        logic hit;       // thread owns a slot
        logic free_any;  // at least one slot is unused
    } t_slot_stat;

    // update command to the thread table, applied to the selected slot
    typedef struct packed {
        logic push;      // claim slot, store tag, fill + 1
        logic pop;       // fill - 1, free slot when it empties
        logic vacate;    // free slot
    } t_slot_cmd;

endpackage

// ===== rtl/per_thread_call_timer_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_thread_call_timer_stack
// Shadow call stack per thread with completed-call timing records.
// ----------------------------------------------------------------------------
// One request is handled at a time. An entry event passes through accept,
// then table lookup and frame write; a return event that pops a frame passes
// through accept, lookup and frame read, then the result from the frame
// memory's registered read port; a return with no open call ends after
// the lookup. A request that produces a record waits in the
// lookup cycle while the previous record is still held in the output
// register. Frames of slot s live at addresses s*STACK_DEPTH ..
// s*STACK_DEPTH+STACK_DEPTH-1 of a single frame memory; the thread table
// sits in flip-flops and needs no clearing pass after reset.
module per_thread_call_timer_stack #(
    parameter int THREAD_SLOTS = 16,
    parameter int STACK_DEPTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // event request
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_mode,
    input  logic [pct_pkg::TID_W-1:0]            i_thread_id,
    input  logic [pct_pkg::CALL_ADDR_W-1:0]      i_call_address,
    input  logic [pct_pkg::TS_W-1:0]             i_timestamp,
    // record request
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [pct_pkg::STATUS_W-1:0]         o_status,
    output logic [pct_pkg::TID_W-1:0]            o_thread_id_out,
    output logic [pct_pkg::CALL_ADDR_W-1:0]      o_callee_addr,
    output logic [pct_pkg::TS_W-1:0]             o_begin_time,
    output logic [pct_pkg::TS_W-1:0]             o_end_time,
    output logic [pct_pkg::DEPTH_OUT_W-1:0]      o_depth
);

    localparam int SLOT_W    = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = THREAD_SLOTS * STACK_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STACK_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
    localparam logic [MEM_AW-1:0] SLOT_BASE = MEM_AW'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;

    // captured request
    logic                            r_mode;
    logic [pct_pkg::TID_W-1:0]       r_tid;
    logic [pct_pkg::CALL_ADDR_W-1:0] r_addr;
    logic [pct_pkg::TS_W-1:0]        r_ts;
    logic [FILL_W-1:0]               r_pop_depth;

    // output register
    logic                            r_o_valid;
    logic                            load_out;
    logic [pct_pkg::STATUS_W-1:0]    n_status;
    logic [pct_pkg::CALL_ADDR_W-1:0] n_callee_addr;
    logic [pct_pkg::TS_W-1:0]        n_begin_time;
    logic [pct_pkg::DEPTH_OUT_W-1:0] n_depth;
    logic                            out_free;

    // table and memory hookup
    pct_pkg::t_slot_stat             slot_stat;
    pct_pkg::t_slot_cmd              slot_cmd;
    logic [SLOT_W-1:0]               sel_idx;
    logic [FILL_W-1:0]               sel_fill;
    logic [MEM_AW-1:0]               slot_base;
    logic                            mem_we;
    logic                            mem_re;
    logic [MEM_AW-1:0]               mem_waddr;
    logic [MEM_AW-1:0]               mem_raddr;
    logic [pct_pkg::CALL_ADDR_W-1:0] rd_address;
    logic [pct_pkg::TS_W-1:0]        rd_begin;

    pct_slot_table #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .SLOT_W       (SLOT_W),
        .FILL_W       (FILL_W)
    ) u_slot_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tid      (r_tid),
        .i_cmd      (slot_cmd),
        .o_stat     (slot_stat),
        .o_sel_idx  (sel_idx),
        .o_sel_fill (sel_fill)
    );

    // frame addresses: push at the current fill, pop one below it
    assign slot_base = MEM_AW'(sel_idx) * SLOT_BASE;
    assign mem_waddr = slot_base + MEM_AW'(sel_fill);
    assign mem_raddr = slot_base + MEM_AW'(sel_fill - FILL_ONE);

    pct_frame_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_frame_ram (
        .i_clk        (i_clk),
        .i_we         (mem_we),
        .i_waddr      (mem_waddr),
        .i_wr_address (r_addr),
        .i_wr_begin   (r_ts),
        .i_re         (mem_re),
        .i_raddr      (mem_raddr),
        .o_rd_address (rd_address),
        .o_rd_begin   (rd_begin)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    // sequencer
    always_comb begin
        n_state       = r_state;
        slot_cmd      = '0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        load_out      = 1'b0;
        n_status      = pct_pkg::ST_DONE;
        n_callee_addr = r_addr;
        n_begin_time  = '0;
        n_depth       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_mode == pct_pkg::MODE_ENTRY) begin
                    if (!slot_stat.hit && !slot_stat.free_any) begin
                        // no slot for a new thread
                        if (out_free) begin
                            load_out = 1'b1;
                            n_status = pct_pkg::ST_TABLE_FULL;
                            n_state  = S_IDLE;
                        end
                    end else if (sel_fill >= FILL_FULL) begin
                        // stack of this thread is full
                        if (out_free) begin
                            load_out = 1'b1;
                            n_status = pct_pkg::ST_STACK_FULL;
                            n_state  = S_IDLE;
                        end
                    end else begin
                        slot_cmd.push = 1'b1;
                        mem_we        = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    if (!slot_stat.hit) begin
                        // return without a stack: nothing to do
                        n_state = S_IDLE;
                    end else if (sel_fill == '0) begin
                        slot_cmd.vacate = 1'b1;
                        n_state         = S_IDLE;
                    end else if (out_free) begin
                        slot_cmd.pop = 1'b1;
                        mem_re       = 1'b1;
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                // popped frame is on the memory read port
                load_out      = 1'b1;
                n_status      = pct_pkg::ST_DONE;
                n_callee_addr = rd_address;
                n_begin_time  = rd_begin;
                n_depth       = pct_pkg::DEPTH_OUT_W'(r_pop_depth);
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // request capture and pop depth
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mode <= i_mode;
            r_tid  <= i_thread_id;
            r_addr <= i_call_address;
            r_ts   <= i_timestamp;
        end
        if (mem_re) begin
            r_pop_depth <= sel_fill - FILL_ONE;
        end
    end

    // record payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_status        <= n_status;
            o_thread_id_out <= r_tid;
            o_callee_addr   <= n_callee_addr;
            o_begin_time    <= n_begin_time;
            o_end_time      <= r_ts;
            o_depth         <= n_depth;
        end
    end

    assign o_valid = r_o_valid;

endmodule

// ===== rtl/pct_frame_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_frame_ram
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pct_frame_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic [pct_pkg::CALL_ADDR_W-1:0]    i_wr_address,
    input  logic [pct_pkg::TS_W-1:0]           i_wr_begin,
    input  logic                               i_re,
    input  logic [AW-1:0]                      i_raddr,
    output logic [pct_pkg::CALL_ADDR_W-1:0]    o_rd_address,
    output logic [pct_pkg::TS_W-1:0]           o_rd_begin
);

    logic [pct_pkg::CALL_ADDR_W-1:0] r_mem_address [DEPTH];
    logic [pct_pkg::TS_W-1:0]        r_mem_begin   [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_address[i_waddr] <= i_wr_address;
            r_mem_begin[i_waddr]   <= i_wr_begin;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rd_address <= r_mem_address[i_raddr];
            o_rd_begin   <= r_mem_begin[i_raddr];
        end
    end

endmodule

// ===== rtl/pct_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_slot_table
// Thread table: slot tags, valid bits and stack fill counts with lookup.
// ----------------------------------------------------------------------------
module pct_slot_table #(
    parameter int THREAD_SLOTS = 16,
    parameter int SLOT_W       = 4,
    parameter int FILL_W       = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pct_pkg::TID_W-1:0]    i_tid,
    input  pct_pkg::t_slot_cmd           i_cmd,
    output pct_pkg::t_slot_stat          o_stat,
    output logic [SLOT_W-1:0]            o_sel_idx,
    output logic [FILL_W-1:0]            o_sel_fill
);

    localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

    logic                      r_valid [THREAD_SLOTS];
    logic [pct_pkg::TID_W-1:0] r_tag   [THREAD_SLOTS];
    logic [FILL_W-1:0]         r_fill  [THREAD_SLOTS];

    logic              hit;
    logic              free_any;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;

    // tag match: at most one valid slot carries a given thread
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int s = 0; s < THREAD_SLOTS; s++) begin
            if (r_valid[s] && (r_tag[s] == i_tid)) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(s);
            end
        end
    end

    // lowest unused slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int s = THREAD_SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    assign o_stat.hit      = hit;
    assign o_stat.free_any = free_any;
    assign o_sel_idx       = hit ? hit_idx : free_idx;
    // a freshly claimed slot starts empty
    assign o_sel_fill      = hit ? r_fill[hit_idx] : '0;

    // valid bits and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < THREAD_SLOTS; s++) begin
                r_valid[s] <= 1'b0;
                r_fill[s]  <= '0;
            end
        end else if (i_cmd.push) begin
            r_valid[o_sel_idx] <= 1'b1;
            r_fill[o_sel_idx]  <= o_sel_fill + FILL_ONE;
        end else if (i_cmd.pop) begin
            r_fill[o_sel_idx] <= o_sel_fill - FILL_ONE;
            if (o_sel_fill == FILL_ONE) begin
                r_valid[o_sel_idx] <= 1'b0;
            end
        end else if (i_cmd.vacate) begin
            r_valid[o_sel_idx] <= 1'b0;
        end
    end

    // tags, meaningful only while the slot is valid
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_tag[o_sel_idx] <= i_tid;
        end
    end

endmodule

// ===== rtl/pct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_checker
// Port-level checks of the call timer stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_thread_call_timer_stack_assert.svh"

module pct_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [pct_pkg::STATUS_W-1:0]         o_status,
    input logic [pct_pkg::TID_W-1:0]            o_thread_id_out,
    input logic [pct_pkg::TS_W-1:0]             o_begin_time,
    input logic [pct_pkg::DEPTH_OUT_W-1:0]      o_depth
);

    // no record survives reset
    `PCT_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !o_valid, "record valid after reset")

    // one request in flight: the block is busy right after an accept
    `PCT_ASSERT(a_busy_after_accept, i_valid && !o_stall |=> o_stall, "accepted while busy")

    // only the three defined status codes appear
    `PCT_ASSERT(a_status_code, o_valid |-> (o_status == pct_pkg::ST_DONE || o_status == pct_pkg::ST_STACK_FULL || o_status == pct_pkg::ST_TABLE_FULL), "bad status")

    // dropped entries carry no begin time and no depth
    `PCT_ASSERT(a_drop_fields, o_valid && o_status != pct_pkg::ST_DONE |-> o_begin_time == '0 && o_depth == '0, "dropped entry fields")

    // a stalled record holds
    `PCT_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_thread_id_out), "stalled record changed")

endmodule

bind per_thread_call_timer_stack pct_checker u_pct_checker (.*);
